/* rtl/box_glyph_rectangle_generator_assert.svh */
// assertion macros for the box glyph rectangle generator
// used by the checker bound to the top level, no other dependencies
`ifndef BOX_GLYPH_RECTANGLE_GENERATOR_ASSERT_SVH
`define BOX_GLYPH_RECTANGLE_GENERATOR_ASSERT_SVH

// clocked assertion, off while reset is asserted
`define BGRG_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("bgrg assertion failed");

// clocked assertion that also holds through reset
`define BGRG_ASSERT_ALWAYS(name, clk, prop) \
  name: assert property (@(posedge clk) prop) \
    else $error("bgrg assertion failed");

`endif

/* rtl/bgrg_pkg.sv */
// shared constants, types and the box-drawing leg table
// used by the top level and the geometry module of the box glyph rectangle generator
`default_nettype none

package bgrg_pkg;

  localparam int unsigned COORD_BITS_DEF = 16;
  localparam int unsigned CP_W           = 21;
  localparam int unsigned STROKE_W       = 10;
  localparam int unsigned MAX_RECTS      = 4;
  localparam int unsigned CNT_W          = 3;
  localparam int unsigned LEG_COUNT      = 76;
  localparam int unsigned CFG_IDX_W      = 1;

  localparam logic [CP_W-1:0] BLOCK_FIRST = 21'h02580;
  localparam logic [CP_W-1:0] BLOCK_LAST  = 21'h0258F;
  localparam logic [CP_W-1:0] BOX_FIRST   = 21'h02500;
  localparam logic [CP_W-1:0] BOX_LAST    = 21'h0254B;

  localparam logic [3:0] BLOCK_UPPER_HALF = 4'd0;
  localparam logic [3:0] BLOCK_FULL       = 4'd8;

  localparam logic [1:0] LEG_NONE  = 2'd0;
  localparam logic [1:0] LEG_LIGHT = 2'd1;
  localparam logic [1:0] LEG_HEAVY = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_LIGHT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_HEAVY = 1'b1;

  localparam logic [STROKE_W-1:0] LIGHT_RESET = 10'd16;
  localparam logic [STROKE_W-1:0] HEAVY_RESET = 10'd32;

  typedef struct packed {
    logic             recognized;
    logic [CNT_W-1:0] count;
  } geom_ctl_t;

  // legs north, east, south, west, two bits each
  localparam logic [7:0] LEG_TABLE [LEG_COUNT] = '{
    8'h11, 8'h22, 8'h44, 8'h88,
    8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00,
    8'h14, 8'h24, 8'h18, 8'h28,
    8'h05, 8'h06, 8'h09, 8'h0A,
    8'h50, 8'h60, 8'h90, 8'hA0,
    8'h41, 8'h42, 8'h81, 8'h82,
    8'h54, 8'h64, 8'h00, 8'h00,
    8'h98, 8'h00, 8'h00, 8'hA8,
    8'h45, 8'h46, 8'h00, 8'h00,
    8'h89, 8'h00, 8'h00, 8'h8A,
    8'h15, 8'h16, 8'h25, 8'h26,
    8'h19, 8'h00, 8'h00, 8'h2A,
    8'h51, 8'h52, 8'h61, 8'h62,
    8'h91, 8'h00, 8'h00, 8'hA2,
    8'h55, 8'h56, 8'h65, 8'h66,
    8'h95, 8'h59, 8'h99, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'hAA
  };

  function automatic logic [7:0] leg_lookup(input logic [6:0] idx);
    logic [7:0] res;
    res = 8'h00;
    if (idx < 7'(LEG_COUNT)) begin
      res = LEG_TABLE[idx];
    end
    return res;
  endfunction

endpackage

`default_nettype wire

/* rtl/box_glyph_rectangle_generator.sv */
// top level of the box glyph rectangle generator: input register, geometry, result buffer
// depends on bgrg_pkg and bgrg_geom
`default_nettype none

// Usage
//   Command channel: drive code_point_i and the four cell edges with start_i high; the
//   word is taken at a rising edge where start_i is high and busy_o is low.
//   Config port: cfg_we_i, cfg_idx_i (0 light stroke, 1 heavy stroke) and cfg_wdata_i
//   write a stroke register at the clock edge; write only while no word is in flight.
//   Result channel: valid_o marks one rectangle for one cycle; last_o flags the final
//   rectangle of a code point; recognized_o low means draw the character as text.
//   When the block is idle, a taken word goes from the input register straight into the result buffer.
//   Throughput: one rectangle per cycle out. A word yields one to four rectangles, so
//   it holds the result buffer until all of them are sent; the next word waits in the input
//   register and busy_o is high only while that register is full and the buffer still
//   has two or more rectangles to send. Words with one rectangle go at one per cycle.
//   The receiver cannot stall: every rectangle is shown for exactly one cycle.
//   Reset: clears the input register, empties the result buffer and loads the stroke
//   registers with light 16 and heavy 32 (1/16 pixel units).
module box_glyph_rectangle_generator #(
  parameter int unsigned CoordBits = bgrg_pkg::COORD_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  output logic                           busy_o,
  input  logic [bgrg_pkg::CP_W-1:0]      code_point_i,
  input  logic signed [CoordBits-1:0]    cell_left_i,
  input  logic signed [CoordBits-1:0]    cell_top_i,
  input  logic signed [CoordBits-1:0]    cell_right_i,
  input  logic signed [CoordBits-1:0]    cell_bottom_i,
  input  logic                           cfg_we_i,
  input  logic [bgrg_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [bgrg_pkg::STROKE_W-1:0]  cfg_wdata_i,
  output logic                           valid_o,
  output logic                           recognized_o,
  output logic signed [CoordBits:0]      rect_left_o,
  output logic signed [CoordBits:0]      rect_top_o,
  output logic signed [CoordBits:0]      rect_right_o,
  output logic signed [CoordBits:0]      rect_bottom_o,
  output logic                           last_o
);
  import bgrg_pkg::*;

  logic [STROKE_W-1:0] light_q, heavy_q;

  logic                        in_vld_q, in_vld_d;
  logic [CP_W-1:0]             cp_q;
  logic signed [CoordBits-1:0] cl_q, ct_q, cr_q, cb_q;

  logic signed [CoordBits:0] g_l [MAX_RECTS];
  logic signed [CoordBits:0] g_t [MAX_RECTS];
  logic signed [CoordBits:0] g_r [MAX_RECTS];
  logic signed [CoordBits:0] g_b [MAX_RECTS];
  geom_ctl_t                 g_ctl;

  logic signed [CoordBits:0] rl_q [MAX_RECTS];
  logic signed [CoordBits:0] rt_q [MAX_RECTS];
  logic signed [CoordBits:0] rr_q [MAX_RECTS];
  logic signed [CoordBits:0] rb_q [MAX_RECTS];
  logic                      rec_q;
  logic [CNT_W-1:0]          cnt_q, cnt_d;

  logic accept, load;

  // stroke registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      light_q <= LIGHT_RESET;
      heavy_q <= HEAVY_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_LIGHT: light_q <= cfg_wdata_i;
        CFG_HEAVY: heavy_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign load   = in_vld_q && (cnt_q <= CNT_W'(1));
  assign busy_o = in_vld_q && !load;
  assign accept = start_i && !busy_o;

  always_comb begin
    in_vld_d = in_vld_q;
    if (accept) begin
      in_vld_d = 1'b1;
    end else if (load) begin
      in_vld_d = 1'b0;
    end
  end

  always_comb begin
    cnt_d = cnt_q;
    if (load) begin
      cnt_d = g_ctl.count;
    end else if (cnt_q != '0) begin
      cnt_d = cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
      cnt_q    <= '0;
    end else begin
      in_vld_q <= in_vld_d;
      cnt_q    <= cnt_d;
    end
  end

  // input word register
  always_ff @(posedge clk_i) begin
    if (accept) begin
      cp_q <= code_point_i;
      cl_q <= cell_left_i;
      ct_q <= cell_top_i;
      cr_q <= cell_right_i;
      cb_q <= cell_bottom_i;
    end
  end

  bgrg_geom #(
    .CoordBits(CoordBits)
  ) u_geom (
    .code_point_i  (cp_q),
    .cell_left_i   (cl_q),
    .cell_top_i    (ct_q),
    .cell_right_i  (cr_q),
    .cell_bottom_i (cb_q),
    .light_stroke_i(light_q),
    .heavy_stroke_i(heavy_q),
    .rect_left_o   (g_l),
    .rect_top_o    (g_t),
    .rect_right_o  (g_r),
    .rect_bottom_o (g_b),
    .ctl_o         (g_ctl)
  );

  // result buffer, entry 0 drives the outputs and the rest shift down
  always_ff @(posedge clk_i) begin
    if (load) begin
      rec_q <= g_ctl.recognized;
      for (int i = 0; i < MAX_RECTS; i++) begin
        rl_q[i] <= g_l[i];
        rt_q[i] <= g_t[i];
        rr_q[i] <= g_r[i];
        rb_q[i] <= g_b[i];
      end
    end else if (cnt_q != '0) begin
      for (int i = 0; i < MAX_RECTS - 1; i++) begin
        rl_q[i] <= rl_q[i+1];
        rt_q[i] <= rt_q[i+1];
        rr_q[i] <= rr_q[i+1];
        rb_q[i] <= rb_q[i+1];
      end
    end
  end

  assign valid_o       = (cnt_q != '0);
  assign last_o        = (cnt_q == CNT_W'(1));
  assign recognized_o  = rec_q;
  assign rect_left_o   = rl_q[0];
  assign rect_top_o    = rt_q[0];
  assign rect_right_o  = rr_q[0];
  assign rect_bottom_o = rb_q[0];

endmodule

`default_nettype wire

/* rtl/bgrg_geom.sv */
// combinational glyph geometry: decodes one code point into up to four rectangles
// depends on bgrg_pkg for the leg table, code point ranges and control struct
`default_nettype none

module bgrg_geom #(
  parameter int unsigned CoordBits = bgrg_pkg::COORD_BITS_DEF
) (
  input  logic [bgrg_pkg::CP_W-1:0]     code_point_i,
  input  logic signed [CoordBits-1:0]   cell_left_i,
  input  logic signed [CoordBits-1:0]   cell_top_i,
  input  logic signed [CoordBits-1:0]   cell_right_i,
  input  logic signed [CoordBits-1:0]   cell_bottom_i,
  input  logic [bgrg_pkg::STROKE_W-1:0] light_stroke_i,
  input  logic [bgrg_pkg::STROKE_W-1:0] heavy_stroke_i,
  output logic signed [CoordBits:0]     rect_left_o   [bgrg_pkg::MAX_RECTS],
  output logic signed [CoordBits:0]     rect_top_o    [bgrg_pkg::MAX_RECTS],
  output logic signed [CoordBits:0]     rect_right_o  [bgrg_pkg::MAX_RECTS],
  output logic signed [CoordBits:0]     rect_bottom_o [bgrg_pkg::MAX_RECTS],
  output bgrg_pkg::geom_ctl_t           ctl_o
);
  import bgrg_pkg::*;

  localparam int unsigned W  = CoordBits + 1;
  localparam int unsigned EW = CoordBits + 12;

  logic signed [EW-1:0] cl_e, ct_e, cr_e, cb_e;
  logic signed [EW-1:0] w_e, h_e, cx_e, cy_e;
  logic signed [EW-1:0] base_e, fac_e, prod_e, q_e;
  logic signed [EW-1:0] blk_l, blk_t, blk_r, blk_b;
  logic signed [EW-1:0] hs_e [MAX_RECTS];
  logic signed [EW-1:0] leg_l [MAX_RECTS];
  logic signed [EW-1:0] leg_t [MAX_RECTS];
  logic signed [EW-1:0] leg_r [MAX_RECTS];
  logic signed [EW-1:0] leg_b [MAX_RECTS];
  logic [1:0]           leg_kind [MAX_RECTS];
  logic [MAX_RECTS-1:0] present;
  logic [1:0]           rank [MAX_RECTS];
  logic [CNT_W-1:0]     box_count;
  logic [3:0]           blk_k, neg_k;
  logic [2:0]           factor;
  logic [7:0]           legs;
  logic                 in_blk, in_box, box_ok;

  function automatic logic [STROKE_W-1:0] stroke_of(input logic [1:0] kind,
                                                    input logic [STROKE_W-1:0] light,
                                                    input logic [STROKE_W-1:0] heavy);
    logic [STROKE_W-1:0] res;
    res = '0;
    case (kind)
      LEG_LIGHT: res = light;
      LEG_HEAVY: res = heavy;
      default:   res = '0;
    endcase
    return res;
  endfunction

  assign cl_e = EW'(cell_left_i);
  assign ct_e = EW'(cell_top_i);
  assign cr_e = EW'(cell_right_i);
  assign cb_e = EW'(cell_bottom_i);
  assign w_e  = cr_e - cl_e;
  assign h_e  = cb_e - ct_e;
  assign cx_e = (cl_e + cr_e) >>> 1;
  assign cy_e = (ct_e + cb_e) >>> 1;

  assign in_blk = (code_point_i >= BLOCK_FIRST) && (code_point_i <= BLOCK_LAST);
  assign in_box = (code_point_i >= BOX_FIRST) && (code_point_i <= BOX_LAST);
  assign legs   = leg_lookup(code_point_i[6:0]);
  assign box_ok = in_box && (legs != 8'h00);

  // block elements: one eighth-step multiply, floor by arithmetic shift
  assign blk_k  = code_point_i[3:0];
  assign neg_k  = 4'd0 - blk_k;
  assign factor = (blk_k == BLOCK_UPPER_HALF) ? 3'd4 : (blk_k[3] ? neg_k[2:0] : blk_k[2:0]);
  assign base_e = blk_k[3] ? w_e : h_e;
  assign fac_e  = EW'(factor);
  assign prod_e = base_e * fac_e;
  assign q_e    = prod_e >>> 3;

  always_comb begin
    blk_l = cl_e;
    blk_t = ct_e;
    blk_r = cr_e;
    blk_b = cb_e;
    if (blk_k == BLOCK_UPPER_HALF) begin
      blk_b = ct_e + q_e;
    end else if (!blk_k[3]) begin
      blk_t = cb_e - q_e;
    end else if (blk_k != BLOCK_FULL) begin
      blk_r = cl_e + q_e;
    end
  end

  // leg order north, south, west, east
  assign leg_kind[0] = legs[7:6];
  assign leg_kind[1] = legs[3:2];
  assign leg_kind[2] = legs[1:0];
  assign leg_kind[3] = legs[5:4];

  always_comb begin
    for (int j = 0; j < MAX_RECTS; j++) begin
      hs_e[j]    = EW'(stroke_of(leg_kind[j], light_stroke_i, heavy_stroke_i) >> 1);
      present[j] = (leg_kind[j] != LEG_NONE);
    end
    leg_l[0] = cx_e - hs_e[0];  leg_t[0] = ct_e;
    leg_r[0] = cx_e + hs_e[0];  leg_b[0] = cy_e + hs_e[0];
    leg_l[1] = cx_e - hs_e[1];  leg_t[1] = cy_e - hs_e[1];
    leg_r[1] = cx_e + hs_e[1];  leg_b[1] = cb_e;
    leg_l[2] = cl_e;            leg_t[2] = cy_e - hs_e[2];
    leg_r[2] = cx_e + hs_e[2];  leg_b[2] = cy_e + hs_e[2];
    leg_l[3] = cx_e - hs_e[3];  leg_t[3] = cy_e - hs_e[3];
    leg_r[3] = cr_e;            leg_b[3] = cy_e + hs_e[3];
  end

  always_comb begin
    rank[0] = 2'd0;
    for (int j = 1; j < MAX_RECTS; j++) begin
      rank[j] = rank[j-1] + 2'(present[j-1]);
    end
    box_count = CNT_W'(present[0]) + CNT_W'(present[1])
              + CNT_W'(present[2]) + CNT_W'(present[3]);
  end

  always_comb begin
    for (int s = 0; s < MAX_RECTS; s++) begin
      rect_left_o[s]   = '0;
      rect_top_o[s]    = '0;
      rect_right_o[s]  = '0;
      rect_bottom_o[s] = '0;
    end
    ctl_o.recognized = 1'b0;
    ctl_o.count      = CNT_W'(1);
    if (in_blk) begin
      ctl_o.recognized = 1'b1;
      rect_left_o[0]   = blk_l[W-1:0];
      rect_top_o[0]    = blk_t[W-1:0];
      rect_right_o[0]  = blk_r[W-1:0];
      rect_bottom_o[0] = blk_b[W-1:0];
    end else if (box_ok) begin
      ctl_o.recognized = 1'b1;
      ctl_o.count      = box_count;
      for (int s = 0; s < MAX_RECTS; s++) begin
        for (int j = 0; j < MAX_RECTS; j++) begin
          if (present[j] && (rank[j] == 2'(s))) begin
            rect_left_o[s]   = leg_l[j][W-1:0];
            rect_top_o[s]    = leg_t[j][W-1:0];
            rect_right_o[s]  = leg_r[j][W-1:0];
            rect_bottom_o[s] = leg_b[j][W-1:0];
          end
        end
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/bgrg_checker.sv */
// port-level checker for the box glyph rectangle generator, bound to the top level
// depends on box_glyph_rectangle_generator_assert.svh
`default_nettype none

`include "box_glyph_rectangle_generator_assert.svh"

module bgrg_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic start_i,
  input logic busy_i,
  input logic valid_i,
  input logic last_i,
  input logic recognized_i
);

  // unrecognized code points give a single rectangle
  `BGRG_ASSERT_ALWAYS(a_unrec_is_last, clk_i, (valid_i && !recognized_i) |-> last_i)

  // backpressure only while rectangles are being sent
  `BGRG_ASSERT(a_busy_needs_output, clk_i, rst_ni, busy_i |-> valid_i)

  // rectangles of one code point go out without gaps
  `BGRG_ASSERT(a_no_gap_in_glyph, clk_i, rst_ni, (valid_i && !last_i) |=> valid_i)

  // a command is only stalled while rectangles are being sent
  `BGRG_ASSERT(a_stall_keeps_busy_path, clk_i, rst_ni, (start_i && busy_i) |-> valid_i)

endmodule

bind box_glyph_rectangle_generator bgrg_checker u_bgrg_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .start_i     (start_i),
  .busy_i      (busy_o),
  .valid_i     (valid_o),
  .last_i      (last_o),
  .recognized_i(recognized_o)
);

`default_nettype wire

/* sim/testbench.sv */
// testbench for box_glyph_rectangle_generator: directed and random code points and cells,
// checked rectangle by rectangle against a predictor of block elements and box-drawing legs
// depends on bgrg_pkg and the rtl of the block
`timescale 1ns / 1ps

module testbench;
  import bgrg_pkg::*;

  localparam int unsigned CB = COORD_BITS_DEF;
  localparam logic [CP_W-1:0] ROUND_FIRST = 21'h0256D;
  localparam logic [CP_W-1:0] CP_MAX      = 21'h10FFFF;

  // legs north, east, south, west, two bits each
  localparam logic [7:0] BOX_LEGS [76] = '{
    8'h11, 8'h22, 8'h44, 8'h88, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h14, 8'h24, 8'h18, 8'h28,
    8'h05, 8'h06, 8'h09, 8'h0A, 8'h50, 8'h60, 8'h90, 8'hA0,
    8'h41, 8'h42, 8'h81, 8'h82, 8'h54, 8'h64, 8'h00, 8'h00,
    8'h98, 8'h00, 8'h00, 8'hA8, 8'h45, 8'h46, 8'h00, 8'h00,
    8'h89, 8'h00, 8'h00, 8'h8A, 8'h15, 8'h16, 8'h25, 8'h26,
    8'h19, 8'h00, 8'h00, 8'h2A, 8'h51, 8'h52, 8'h61, 8'h62,
    8'h91, 8'h00, 8'h00, 8'hA2, 8'h55, 8'h56, 8'h65, 8'h66,
    8'h95, 8'h59, 8'h99, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'hAA
  };

  typedef struct {
    logic                 recognized;
    logic signed [CB:0]   left;
    logic signed [CB:0]   top;
    logic signed [CB:0]   right;
    logic signed [CB:0]   bottom;
    logic                 last;
  } glyph_rect_t;

  logic                   clk_i = 1'b0;
  logic                   rst_ni;
  logic                   start_i;
  logic                   busy_o;
  logic [CP_W-1:0]        code_point_i;
  logic signed [CB-1:0]   cell_left_i;
  logic signed [CB-1:0]   cell_top_i;
  logic signed [CB-1:0]   cell_right_i;
  logic signed [CB-1:0]   cell_bottom_i;
  logic                   cfg_we_i;
  logic [CFG_IDX_W-1:0]   cfg_idx_i;
  logic [STROKE_W-1:0]    cfg_wdata_i;
  logic                   valid_o;
  logic                   recognized_o;
  logic signed [CB:0]     rect_left_o;
  logic signed [CB:0]     rect_top_o;
  logic signed [CB:0]     rect_right_o;
  logic signed [CB:0]     rect_bottom_o;
  logic                   last_o;

  glyph_rect_t          expected_rects [$];
  logic [STROKE_W-1:0]  light_width;
  logic [STROKE_W-1:0]  heavy_width;
  int                   mismatch_count = 0;
  bit                   gaps_on = 1'b1;

  box_glyph_rectangle_generator u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start_i),
    .busy_o        (busy_o),
    .code_point_i  (code_point_i),
    .cell_left_i   (cell_left_i),
    .cell_top_i    (cell_top_i),
    .cell_right_i  (cell_right_i),
    .cell_bottom_i (cell_bottom_i),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .valid_o       (valid_o),
    .recognized_o  (recognized_o),
    .rect_left_o   (rect_left_o),
    .rect_top_o    (rect_top_o),
    .rect_right_o  (rect_right_o),
    .rect_bottom_o (rect_bottom_o),
    .last_o        (last_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial begin
    #2ms;
    $display("testbench: done, errors");
    $finish;
  end

  function automatic logic [STROKE_W-1:0] stroke_for(input logic [1:0] leg);
    logic [STROKE_W-1:0] s;
    s = '0;
    if (leg == LEG_LIGHT) s = light_width;
    else if (leg == LEG_HEAVY) s = heavy_width;
    return s;
  endfunction

  function automatic void push_rect(input logic rec, input longint l, input longint t,
                                    input longint r, input longint b, input logic fin);
    glyph_rect_t g;
    g.recognized = rec;
    g.left       = l[CB:0];
    g.top        = t[CB:0];
    g.right      = r[CB:0];
    g.bottom     = b[CB:0];
    g.last       = fin;
    expected_rects.push_back(g);
  endfunction

  // expected rectangles for one accepted word
  function automatic void predict_glyph(input logic [CP_W-1:0] cp,
                                        input logic signed [CB-1:0] cl,
                                        input logic signed [CB-1:0] ct,
                                        input logic signed [CB-1:0] cr,
                                        input logic signed [CB-1:0] cb);
    longint     l, t, r, b, w, h, cx, cy, hs;
    longint     ql [4];
    longint     qt [4];
    longint     qr [4];
    longint     qb [4];
    int         k, n;
    logic [7:0] legs;
    l = cl;
    t = ct;
    r = cr;
    b = cb;
    n = 0;
    legs = 8'h00;
    if (cp >= BLOCK_FIRST && cp <= BLOCK_LAST) begin
      k = int'(cp - BLOCK_FIRST);
      w = r - l;
      h = b - t;
      if (k == int'(BLOCK_UPPER_HALF)) b = t + ((h * 4) >>> 3);
      else if (k < int'(BLOCK_FULL)) t = b - ((h * k) >>> 3);
      else if (k > int'(BLOCK_FULL)) r = l + ((w * (16 - k)) >>> 3);
      push_rect(1'b1, l, t, r, b, 1'b1);
      return;
    end
    if (cp >= BOX_FIRST && cp <= BOX_LAST) legs = BOX_LEGS[int'(cp - BOX_FIRST)];
    if (legs == 8'h00) begin
      push_rect(1'b0, 0, 0, 0, 0, 1'b1);
      return;
    end
    cx = (l + r) >>> 1;
    cy = (t + b) >>> 1;
    // north, south, west, east
    if (legs[7:6] != LEG_NONE) begin
      hs = longint'(stroke_for(legs[7:6])) >>> 1;
      ql[n] = cx - hs; qt[n] = t; qr[n] = cx + hs; qb[n] = cy + hs; n++;
    end
    if (legs[3:2] != LEG_NONE) begin
      hs = longint'(stroke_for(legs[3:2])) >>> 1;
      ql[n] = cx - hs; qt[n] = cy - hs; qr[n] = cx + hs; qb[n] = b; n++;
    end
    if (legs[1:0] != LEG_NONE) begin
      hs = longint'(stroke_for(legs[1:0])) >>> 1;
      ql[n] = l; qt[n] = cy - hs; qr[n] = cx + hs; qb[n] = cy + hs; n++;
    end
    if (legs[5:4] != LEG_NONE) begin
      hs = longint'(stroke_for(legs[5:4])) >>> 1;
      ql[n] = cx - hs; qt[n] = cy - hs; qr[n] = r; qb[n] = cy + hs; n++;
    end
    for (int i = 0; i < n; i++) begin
      push_rect(1'b1, ql[i], qt[i], qr[i], qb[i], i == n - 1);
    end
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    mismatch_count++;
    if (mismatch_count <= 50) begin
      $display("%0t mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
    end
  endtask

  always @(posedge clk_i) begin : check_results
    glyph_rect_t want;
    if (rst_ni && valid_o) begin
      if (expected_rects.size() == 0) begin
        report_mismatch("rectangle with none pending", rect_left_o, 0);
      end else begin
        want = expected_rects.pop_front();
        if (recognized_o !== want.recognized)
          report_mismatch("recognized", recognized_o, want.recognized);
        if (rect_left_o !== want.left) report_mismatch("rect_left", rect_left_o, want.left);
        if (rect_top_o !== want.top) report_mismatch("rect_top", rect_top_o, want.top);
        if (rect_right_o !== want.right) report_mismatch("rect_right", rect_right_o, want.right);
        if (rect_bottom_o !== want.bottom)
          report_mismatch("rect_bottom", rect_bottom_o, want.bottom);
        if (last_o !== want.last) report_mismatch("last", last_o, want.last);
      end
    end
  end

  task automatic send_word(input logic [CP_W-1:0] cp, input logic signed [CB-1:0] l,
                           input logic signed [CB-1:0] t, input logic signed [CB-1:0] r,
                           input logic signed [CB-1:0] b);
    while (gaps_on && $urandom_range(0, 99) < 24) begin
      start_i <= 1'b0;
      @(posedge clk_i);
    end
    start_i       <= 1'b1;
    code_point_i  <= cp;
    cell_left_i   <= l;
    cell_top_i    <= t;
    cell_right_i  <= r;
    cell_bottom_i <= b;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    predict_glyph(cp, l, t, r, b);
  endtask

  task automatic wait_idle();
    start_i <= 1'b0;
    while (expected_rects.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_strokes(input logic [STROKE_W-1:0] light, input logic [STROKE_W-1:0] heavy);
    wait_idle();
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= CFG_LIGHT;
    cfg_wdata_i <= light;
    @(posedge clk_i);
    cfg_idx_i   <= CFG_HEAVY;
    cfg_wdata_i <= heavy;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    light_width = light;
    heavy_width = heavy;
    @(posedge clk_i);
  endtask

  function automatic logic [CP_W-1:0] random_code_point();
    int unsigned sel;
    logic [CP_W-1:0] cp;
    sel = $urandom_range(0, 99);
    if (sel < 45) cp = BOX_FIRST + CP_W'($urandom_range(0, 75));
    else if (sel < 75) cp = BLOCK_FIRST + CP_W'($urandom_range(0, 15));
    else if (sel < 80) cp = ROUND_FIRST + CP_W'($urandom_range(0, 3));
    else if (sel < 85) begin
      case ($urandom_range(0, 3))
        0: cp = BOX_FIRST - 1'b1;
        1: cp = BOX_LAST + 1'b1;
        2: cp = BLOCK_FIRST - 1'b1;
        default: cp = BLOCK_LAST + 1'b1;
      endcase
    end else cp = CP_W'($urandom_range(0, CP_MAX));
    return cp;
  endfunction

  task automatic random_cell(output logic signed [CB-1:0] l, output logic signed [CB-1:0] t,
                             output logic signed [CB-1:0] r, output logic signed [CB-1:0] b);
    int x0, y0;
    if ($urandom_range(0, 99) < 75) begin
      x0 = int'($urandom_range(0, 60000)) - 32768;
      y0 = int'($urandom_range(0, 60000)) - 32768;
      l = CB'(x0);
      t = CB'(y0);
      r = CB'(x0 + int'($urandom_range(0, 640)));
      b = CB'(y0 + int'($urandom_range(0, 640)));
    end else begin
      l = CB'($urandom);
      t = CB'($urandom);
      r = CB'($urandom);
      b = CB'($urandom);
    end
  endtask

  task automatic send_random(input int count, input bit box_only);
    logic [CP_W-1:0]      cp;
    logic signed [CB-1:0] l, t, r, b;
    for (int i = 0; i < count; i++) begin
      cp = box_only ? BOX_FIRST + CP_W'($urandom_range(0, 75)) : random_code_point();
      random_cell(l, t, r, b);
      send_word(cp, l, t, r, b);
    end
  endtask

  task automatic test_block_elements();
    send_word(21'h02580, 16'sd160, 16'sd320, 16'sd288, 16'sd581);
    send_word(21'h02581, -16'sd97, -16'sd300, 16'sd31, -16'sd45);
    send_word(21'h02587, 16'sd0, 16'sd0, 16'sd128, 16'sd255);
    send_word(21'h02588, 16'sd10, 16'sd20, 16'sd138, 16'sd276);
    send_word(21'h02589, -16'sd200, 16'sd50, -16'sd73, 16'sd306);
    send_word(21'h0258F, 16'sd33, 16'sd0, 16'sd160, 16'sd256);
  endtask

  task automatic test_box_legs();
    send_word(21'h02500, 16'sd0, 16'sd0, 16'sd128, 16'sd256);
    send_word(21'h02501, 16'sd1, 16'sd3, 16'sd130, 16'sd259);
    send_word(21'h02502, -16'sd129, -16'sd255, 16'sd0, 16'sd0);
    send_word(21'h02503, 16'sd500, -16'sd7, 16'sd627, 16'sd250);
    send_word(21'h0250C, 16'sd64, 16'sd64, 16'sd191, 16'sd319);
    send_word(21'h0253C, -16'sd1, -16'sd1, 16'sd126, 16'sd254);
    send_word(21'h0254B, 16'sd1000, 16'sd2000, 16'sd1128, 16'sd2256);
  endtask

  task automatic test_unknown_code_points();
    send_word(21'h02504, 16'sd0, 16'sd0, 16'sd128, 16'sd256);
    send_word(21'h0256D, 16'sd0, 16'sd0, 16'sd128, 16'sd256);
    send_word(21'h00000, -16'sd1, -16'sd1, -16'sd1, -16'sd1);
    send_word(CP_MAX, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
    send_word(21'h0257F, 16'sh5555, 16'shAAAA, 16'sh0F0F, 16'shF0F0);
  endtask

  task automatic test_cell_extremes();
    send_word(21'h0254B, -16'sd32768, -16'sd32768, 16'sd32767, 16'sd32767);
    send_word(21'h02589, -16'sd32768, -16'sd32768, 16'sd32767, 16'sd32767);
    send_word(21'h02580, 16'sd32767, 16'sd32767, -16'sd32768, -16'sd32768);
    send_word(21'h0253C, 16'sd100, 16'sd200, -16'sd50, -16'sd300);
    send_word(21'h02587, 16'sd100, 16'sd200, -16'sd50, -16'sd300);
  endtask

  task automatic test_stroke_settings();
    set_strokes(10'd0, 10'd0);
    send_word(21'h0254B, 16'sd0, 16'sd0, 16'sd128, 16'sd256);
    send_random(6, 1'b1);
    set_strokes(10'd1023, 10'd1023);
    send_word(21'h0254B, 16'sd32767, 16'sd32767, -16'sd32768, -16'sd32768);
    send_random(6, 1'b1);
    set_strokes(10'd1, 10'd3);
    send_random(6, 1'b1);
    set_strokes(10'd17, 10'd1022);
    send_random(6, 1'b1);
    set_strokes(10'd16, 10'd32);
  endtask

  task automatic test_random_mix();
    for (int chunk = 0; chunk < 6; chunk++) begin
      set_strokes(STROKE_W'($urandom_range(0, 1023)), STROKE_W'($urandom_range(0, 1023)));
      gaps_on = (chunk != 2);
      send_random(22, 1'b0);
    end
    gaps_on = 1'b1;
  endtask

  initial begin
    rst_ni        <= 1'b0;
    start_i       <= 1'b0;
    code_point_i  <= '0;
    cell_left_i   <= '0;
    cell_top_i    <= '0;
    cell_right_i  <= '0;
    cell_bottom_i <= '0;
    cfg_we_i      <= 1'b0;
    cfg_idx_i     <= CFG_LIGHT;
    cfg_wdata_i   <= '0;
    light_width   = LIGHT_RESET;
    heavy_width   = HEAVY_RESET;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_box_legs();
    test_block_elements();
    test_unknown_code_points();
    test_cell_extremes();
    test_stroke_settings();
    test_random_mix();

    wait_idle();
    repeat (6) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule
